// ===== hw/rtl/hpc_pkg.sv =====
// hpc_pkg: shared types, codes and constants for the hash table probe chain block.
// Used by hpc_rem, hash_table_probe_chain and the bench; depends on nothing.
`timescale 1ns / 1ps

package hpc_pkg;

    localparam int CFG_W         = 5;
    localparam int KEY_W         = 31;
    localparam int PAY_W         = 31;
    localparam int LABEL_W       = 64;
    localparam int IDX_W         = 4;
    localparam int SLOTS_DEFAULT = 16;
    localparam logic [CFG_W-1:0] SIZE_RESET = 5'd10;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_SEARCH = 2'd1;
    localparam logic [1:0] REQ_MODIFY = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_MISSING = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [KEY_W-1:0]   record_key;
        logic [PAY_W-1:0]   record_pay;
        logic [LABEL_W-1:0] record_label;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [IDX_W-1:0]   slot_index;
        logic [PAY_W-1:0]   found_pay;
        logic [LABEL_W-1:0] found_label;
    } out_item_t;

    typedef struct packed {
        logic             done;
        logic [CFG_W-1:0] rem;
    } rem_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_HOME,
        S_PROBE,
        S_RD,
        S_CHK,
        S_LINK,
        S_PUT,
        S_RESP
    } state_t;

endpackage

// ===== hw/rtl/hpc_rem.sv =====
// hpc_rem: restoring remainder unit, one key bit per cycle (key mod size).
// Depends on hpc_pkg.
`timescale 1ns / 1ps

module hpc_rem (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [hpc_pkg::KEY_W-1:0] dividend,
    input  logic [hpc_pkg::CFG_W-1:0] divisor,
    output hpc_pkg::rem_res_t         res
);

    localparam int CNT_W = $clog2(hpc_pkg::KEY_W);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [hpc_pkg::KEY_W-1:0] dvd_reg, dvd_next;
    logic [hpc_pkg::CFG_W-1:0] rem_reg, rem_next;
    logic [hpc_pkg::CFG_W-1:0] dsr_reg, dsr_next;
    logic [hpc_pkg::CFG_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, dvd_reg[hpc_pkg::KEY_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(hpc_pkg::KEY_W - 1);
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[hpc_pkg::KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
                rem_next = hpc_pkg::CFG_W'(trial - {1'b0, dsr_reg});
            else
                rem_next = trial[hpc_pkg::CFG_W-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign res.done = done_reg;
    assign res.rem  = rem_reg;

endmodule

// ===== hw/rtl/hash_table_probe_chain.sv =====
// hash_table_probe_chain: keyed record table, open addressing with chaining
// without replacement, run by a small sequencer. Depends on hpc_pkg, hpc_rem.
//
//  channel | signals                   | transfer when
//  cfg     | cfg_we, cfg_data          | cfg_we high (slots in use)
//  req     | req_valid, req_ready, req | req_valid && req_ready
//  rsp     | rsp_valid, rsp_ready, rsp | rsp_valid && rsp_ready
//
// Clear goes straight to the response. Other requests first take key mod size
// in hpc_rem bit by bit and pick up the remainder; an insert whose home slot is
// taken then probes the slots above home for a free one, and the chain walk reads
// the slot memory once per step before the result is finished.
// req_ready is high only while the sequencer is idle; a result waiting in the
// output register does not block the next transfer. Reset empties the table.
`timescale 1ns / 1ps

module hash_table_probe_chain #(
    parameter int TABLE_SLOTS = hpc_pkg::SLOTS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [hpc_pkg::CFG_W-1:0] cfg_data,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  hpc_pkg::in_item_t         req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output hpc_pkg::out_item_t        rsp
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int NEXT_W = SLOT_W + 1;
    localparam int CMP_W  = ((SLOT_W > hpc_pkg::CFG_W) ? SLOT_W : hpc_pkg::CFG_W) + 1;
    localparam int DATA_W = hpc_pkg::KEY_W + hpc_pkg::PAY_W + hpc_pkg::LABEL_W;
    localparam logic [NEXT_W-1:0] LINK_END = NEXT_W'(TABLE_SLOTS);

    hpc_pkg::state_t           state_reg, state_next;
    logic [hpc_pkg::CFG_W-1:0] cfg_size_reg;
    logic [hpc_pkg::CFG_W-1:0] size_reg, size_next;
    logic [TABLE_SLOTS-1:0]    used_reg, used_next;
    hpc_pkg::in_item_t         item_reg, item_next;
    logic [SLOT_W-1:0]         home_reg, home_next;
    logic [SLOT_W-1:0]         cur_reg, cur_next;
    logic [SLOT_W-1:0]         free_reg, free_next;
    logic [CMP_W-1:0]          probe_reg, probe_next;
    logic [CMP_W-1:0]          steps_reg, steps_next;
    hpc_pkg::out_item_t        res_reg, res_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    hpc_pkg::out_item_t        rsp_reg, rsp_next;

    logic [DATA_W-1:0] data_mem [TABLE_SLOTS];
    logic [NEXT_W-1:0] link_mem [TABLE_SLOTS];
    logic [DATA_W-1:0] data_q;
    logic [NEXT_W-1:0] link_q;
    logic              data_we, link_we;
    logic [SLOT_W-1:0] data_wa, link_wa;
    logic [DATA_W-1:0] data_wd;
    logic [NEXT_W-1:0] link_wd;

    logic                      req_xfer;
    logic                      rem_start;
    hpc_pkg::rem_res_t         rem_res;
    logic [hpc_pkg::CFG_W-1:0] eff_size;
    logic [CMP_W-1:0]          size_cmp;
    logic [hpc_pkg::KEY_W-1:0] q_key;
    logic [hpc_pkg::PAY_W-1:0] q_pay;
    logic [hpc_pkg::LABEL_W-1:0] q_label;
    logic                      key_hit;
    logic                      link_end;
    logic                      step_limit;
    logic                      probe_out;
    logic                      is_insert;

    assign req_xfer  = req_valid && req_ready;
    assign rem_start = req_xfer && (req.req_type != hpc_pkg::REQ_CLEAR);
    assign size_cmp  = CMP_W'(size_reg);
    assign is_insert = (item_reg.req_type == hpc_pkg::REQ_INSERT);
    assign {q_key, q_pay, q_label} = data_q;
    assign key_hit    = !is_insert && (q_key == item_reg.record_key);
    assign link_end   = (CMP_W'(link_q) >= size_cmp) || !used_reg[link_q[SLOT_W-1:0]];
    assign step_limit = ((steps_reg + 1'b1) == size_cmp);
    assign probe_out  = (probe_reg >= size_cmp);

    always_comb
    begin
        if (cfg_size_reg == '0)
            eff_size = hpc_pkg::CFG_W'(1);
        else if (CMP_W'(cfg_size_reg) > CMP_W'(TABLE_SLOTS))
            eff_size = hpc_pkg::CFG_W'(TABLE_SLOTS);
        else
            eff_size = cfg_size_reg;
    end

    hpc_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (req.record_key),
        .divisor  (eff_size),
        .res      (rem_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hpc_pkg::S_IDLE:
                if (req_xfer)
                    state_next = (req.req_type == hpc_pkg::REQ_CLEAR) ?
                                 hpc_pkg::S_RESP : hpc_pkg::S_DIV;
            hpc_pkg::S_DIV:
                if (rem_res.done)
                    state_next = hpc_pkg::S_HOME;
            hpc_pkg::S_HOME:
                if (is_insert)
                    state_next = used_reg[home_reg] ? hpc_pkg::S_PROBE : hpc_pkg::S_PUT;
                else
                    state_next = used_reg[home_reg] ? hpc_pkg::S_RD : hpc_pkg::S_RESP;
            hpc_pkg::S_PROBE:
                if (probe_out)
                    state_next = hpc_pkg::S_RESP;
                else if (!used_reg[probe_reg[SLOT_W-1:0]])
                    state_next = hpc_pkg::S_RD;
            hpc_pkg::S_RD:
                state_next = hpc_pkg::S_CHK;
            hpc_pkg::S_CHK:
                if (key_hit)
                    state_next = hpc_pkg::S_RESP;
                else if (link_end || step_limit)
                    state_next = is_insert ? hpc_pkg::S_LINK : hpc_pkg::S_RESP;
                else
                    state_next = hpc_pkg::S_RD;
            hpc_pkg::S_LINK:
                state_next = hpc_pkg::S_PUT;
            hpc_pkg::S_PUT:
                state_next = hpc_pkg::S_RESP;
            hpc_pkg::S_RESP:
                if (!rsp_valid_reg || rsp_ready)
                    state_next = hpc_pkg::S_IDLE;
            default:
                state_next = hpc_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        req_ready      = (state_reg == hpc_pkg::S_IDLE);
        size_next      = size_reg;
        used_next      = used_reg;
        item_next      = item_reg;
        home_next      = home_reg;
        cur_next       = cur_reg;
        free_next      = free_reg;
        probe_next     = probe_reg;
        steps_next     = steps_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        data_we        = 1'b0;
        data_wa        = cur_reg;
        data_wd        = {item_reg.record_key, item_reg.record_pay, item_reg.record_label};
        link_we        = 1'b0;
        link_wa        = cur_reg;
        link_wd        = NEXT_W'(free_reg);
        case (state_reg)
            hpc_pkg::S_IDLE:
                if (req_xfer)
                begin
                    item_next = req;
                    size_next = eff_size;
                    res_next  = '0;
                    if (req.req_type == hpc_pkg::REQ_CLEAR)
                        used_next = '0;
                end
            hpc_pkg::S_DIV:
                home_next = SLOT_W'(rem_res.rem);
            hpc_pkg::S_HOME:
            begin
                free_next  = home_reg;
                cur_next   = home_reg;
                steps_next = '0;
                probe_next = CMP_W'(home_reg) + 1'b1;
                if (!is_insert && !used_reg[home_reg])
                    res_next.status = hpc_pkg::STAT_MISSING;
            end
            hpc_pkg::S_PROBE:
                if (probe_out)
                    res_next.status = hpc_pkg::STAT_FULL;
                else if (!used_reg[probe_reg[SLOT_W-1:0]])
                    free_next = probe_reg[SLOT_W-1:0];
                else
                    probe_next = probe_reg + 1'b1;
            hpc_pkg::S_CHK:
                if (key_hit)
                begin
                    res_next.status     = hpc_pkg::STAT_OK;
                    res_next.slot_index = hpc_pkg::IDX_W'(cur_reg);
                    if (item_reg.req_type == hpc_pkg::REQ_MODIFY)
                    begin
                        data_we              = 1'b1;
                        data_wd              = {q_key, item_reg.record_pay,
                                                item_reg.record_label};
                        res_next.found_pay   = item_reg.record_pay;
                        res_next.found_label = item_reg.record_label;
                    end
                    else
                    begin
                        res_next.found_pay   = q_pay;
                        res_next.found_label = q_label;
                    end
                end
                else if (link_end)
                begin
                    if (!is_insert)
                        res_next.status = hpc_pkg::STAT_MISSING;
                end
                else
                begin
                    cur_next   = link_q[SLOT_W-1:0];
                    steps_next = steps_reg + 1'b1;
                    if (step_limit && !is_insert)
                        res_next.status = hpc_pkg::STAT_MISSING;
                end
            hpc_pkg::S_LINK:
                link_we = 1'b1;
            hpc_pkg::S_PUT:
            begin
                data_we             = 1'b1;
                data_wa             = free_reg;
                link_we             = 1'b1;
                link_wa             = free_reg;
                link_wd             = LINK_END;
                used_next[free_reg] = 1'b1;
                res_next.status     = hpc_pkg::STAT_OK;
                res_next.slot_index = hpc_pkg::IDX_W'(free_reg);
            end
            hpc_pkg::S_RESP:
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hpc_pkg::S_IDLE;
            cfg_size_reg  <= hpc_pkg::SIZE_RESET;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
                cfg_size_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg  <= size_next;
        item_reg  <= item_next;
        home_reg  <= home_next;
        cur_reg   <= cur_next;
        free_reg  <= free_next;
        probe_reg <= probe_next;
        steps_reg <= steps_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
            data_mem[data_wa] <= data_wd;
        if (link_we)
            link_mem[link_wa] <= link_wd;
        data_q <= data_mem[cur_reg];
        link_q <= link_mem[cur_reg];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> !req_ready)
        else $error("req_ready high right after a transfer");

    a_put_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hpc_pkg::S_PUT || state_reg == hpc_pkg::S_LINK) |->
        !used_reg[free_reg])
        else $error("insert target slot already in use");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != hpc_pkg::STAT_OK) |->
        (rsp.slot_index == '0 && rsp.found_pay == '0 && rsp.found_label == '0))
        else $error("miss or full result carries nonzero fields");

    a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hpc_pkg::S_CHK) |-> ($past(state_reg) == hpc_pkg::S_RD))
        else $error("chain check without a memory read");

    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != hpc_pkg::S_IDLE && state_reg != hpc_pkg::S_RESP) |->
        (size_reg != '0))
        else $error("table size zero during a walk");
`endif

endmodule

// ===== tb/hash_table_probe_chain_tb.sv =====
// hash_table_probe_chain_tb: self-checking bench for the keyed record table with probe chains.
// Directed table then random phases over several table sizes, scored against an in-bench model.
// Depends on hpc_pkg and hash_table_probe_chain.
`timescale 1ns / 1ps

module hash_table_probe_chain_tb;
    import hpc_pkg::*;

    localparam int NSLOT       = SLOTS_DEFAULT;
    localparam int NUM_PHASES  = 9;
    localparam int PHASE_ITEMS = 95;
    localparam int POOL_N      = 12;
    localparam logic [KEY_W-1:0]   KMAX = {KEY_W{1'b1}};
    localparam logic [PAY_W-1:0]   PMAX = {PAY_W{1'b1}};
    localparam logic [LABEL_W-1:0] LMAX = {LABEL_W{1'b1}};
    localparam logic [LABEL_W-1:0] LBL_A = 64'h5555_5555_5555_5555;
    localparam logic [LABEL_W-1:0] LBL_B = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [LABEL_W-1:0] LBL_BOB = 64'h0000_0000_0042_4F42;

    typedef struct packed {
        logic             set_size;
        logic [CFG_W-1:0] size_val;
        in_item_t         item;
        logic             typed;
        out_item_t        want;
    } plan_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             req_valid = 1'b0;
    logic             req_ready;
    in_item_t         req = '0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    out_item_t        rsp;

    // model of the table
    logic [CFG_W-1:0]   tbl_size_reg = SIZE_RESET;
    bit                 tbl_used  [NSLOT];
    logic [KEY_W-1:0]   tbl_key   [NSLOT];
    logic [PAY_W-1:0]   tbl_pay   [NSLOT];
    logic [LABEL_W-1:0] tbl_label [NSLOT];
    int                 tbl_link  [NSLOT];

    out_item_t   replies_due [$];
    plan_row_t   plan [$];
    logic [KEY_W-1:0] key_pool [POOL_N];
    bit          steady = 1'b0;
    int          mismatches = 0;

    hash_table_probe_chain dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    initial
    begin
        foreach (tbl_used[i])
        begin
            tbl_used[i] = 1'b0;
        end
    end

    // returns slot holding key (want_key) or chain tail; -1 when none
    function automatic int chain_walk(int home, int size, bit want_key, logic [KEY_W-1:0] key);
        int cur;
        int nx;
        cur = home;
        if (cur >= size || !tbl_used[cur])
        begin
            return -1;
        end
        for (int n = 0; n < size; n++)
        begin
            if (want_key && tbl_key[cur] == key)
            begin
                return cur;
            end
            nx = tbl_link[cur];
            if (nx >= size)
            begin
                break;
            end
            if (!tbl_used[nx])
            begin
                break;
            end
            cur = nx;
        end
        return want_key ? -1 : cur;
    endfunction

    function automatic out_item_t apply_table_op(in_item_t it);
        out_item_t r;
        int size;
        int home;
        int s;
        int tail;
        int hit;
        bit open;
        r = '0;
        if (tbl_size_reg == 0)
        begin
            size = 1;
        end
        else if (tbl_size_reg > NSLOT)
        begin
            size = NSLOT;
        end
        else
        begin
            size = int'(tbl_size_reg);
        end
        home = it.record_key % size;
        case (it.req_type)
            REQ_INSERT:
            begin
                s = home;
                open = 1'b1;
                if (tbl_used[home])
                begin
                    open = 1'b0;
                    for (s = home + 1; s < size; s++)
                    begin
                        if (!tbl_used[s])
                        begin
                            open = 1'b1;
                            break;
                        end
                    end
                end
                if (!open)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    if (s != home)
                    begin
                        tail = chain_walk(home, size, 1'b0, '0);
                        if (tail >= 0)
                        begin
                            tbl_link[tail] = s;
                        end
                    end
                    tbl_used[s]  = 1'b1;
                    tbl_key[s]   = it.record_key;
                    tbl_pay[s]   = it.record_pay;
                    tbl_label[s] = it.record_label;
                    tbl_link[s]  = NSLOT;
                    r.status     = STAT_OK;
                    r.slot_index = s[IDX_W-1:0];
                end
            end
            REQ_SEARCH, REQ_MODIFY:
            begin
                hit = chain_walk(home, size, 1'b1, it.record_key);
                if (hit < 0)
                begin
                    r.status = STAT_MISSING;
                end
                else
                begin
                    if (it.req_type == REQ_MODIFY)
                    begin
                        tbl_pay[hit]   = it.record_pay;
                        tbl_label[hit] = it.record_label;
                    end
                    r.status      = STAT_OK;
                    r.slot_index  = hit[IDX_W-1:0];
                    r.found_pay   = tbl_pay[hit];
                    r.found_label = tbl_label[hit];
                end
            end
            default:
            begin
                foreach (tbl_used[i])
                begin
                    tbl_used[i] = 1'b0;
                end
                r.status = STAT_OK;
            end
        endcase
        return r;
    endfunction

    function automatic bit idle_roll();
        return !steady && ($urandom_range(0, 99) < 36);
    endfunction

    task automatic add_row(input logic set_size, input logic [CFG_W-1:0] size_val,
                           input logic [1:0] op, input logic [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] pay, input logic [LABEL_W-1:0] label,
                           input logic typed, input logic [1:0] st,
                           input logic [IDX_W-1:0] idx, input logic [PAY_W-1:0] fpay,
                           input logic [LABEL_W-1:0] flab);
        plan_row_t row;
        row.set_size           = set_size;
        row.size_val           = size_val;
        row.item.req_type      = op;
        row.item.record_key    = key;
        row.item.record_pay    = pay;
        row.item.record_label  = label;
        row.typed              = typed;
        row.want.status        = st;
        row.want.slot_index    = idx;
        row.want.found_pay     = fpay;
        row.want.found_label   = flab;
        plan.push_back(row);
    endtask

    task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
        out_item_t got;
        while (idle_roll())
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        got = apply_table_op(it);
        replies_due.push_back(typed ? want : got);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (replies_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tbl_size_reg = v;
    endtask

    always @(posedge clk)
    begin
        rsp_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 36);
    end

    always @(posedge clk)
    begin : rsp_check
        out_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("rsp transfer with nothing outstanding: %h", rsp);
                mismatches++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    mismatches++;
                end
                if (rsp.slot_index !== want.slot_index)
                begin
                    $error("slot_index: expected %0d, got %0d", want.slot_index,
                           rsp.slot_index);
                    mismatches++;
                end
                if (rsp.found_pay !== want.found_pay)
                begin
                    $error("found_pay: expected %h, got %h", want.found_pay, rsp.found_pay);
                    mismatches++;
                end
                if (rsp.found_label !== want.found_label)
                begin
                    $error("found_label: expected %h, got %h", want.found_label,
                           rsp.found_label);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stim
        in_item_t         it;
        logic [CFG_W-1:0] sz;
        int               roll;
        int               eff;

        // size 10 after reset
        add_row(0, 0, REQ_SEARCH, 0, 0, 0, 1, STAT_MISSING, 0, 0, 0);
        add_row(0, 0, REQ_MODIFY, 5, 7, 1, 1, STAT_MISSING, 0, 0, 0);
        add_row(0, 0, REQ_INSERT, 0, PMAX, LMAX, 1, STAT_OK, 0, 0, 0);
        add_row(0, 0, REQ_SEARCH, 0, 0, 0, 1, STAT_OK, 0, PMAX, LMAX);
        add_row(0, 0, REQ_INSERT, 10, 1, LBL_BOB, 1, STAT_OK, 1, 0, 0);
        add_row(0, 0, REQ_INSERT, 20, 2, LBL_A, 1, STAT_OK, 2, 0, 0);
        add_row(0, 0, REQ_INSERT, 0, 3, LBL_B, 0, 0, 0, 0, 0);
        add_row(0, 0, REQ_SEARCH, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, REQ_MODIFY, 10, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, REQ_SEARCH, 30, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, REQ_INSERT, 9, 9, LBL_A, 0, 0, 0, 0, 0);
        add_row(0, 0, REQ_INSERT, 19, 19, LBL_B, 1, STAT_FULL, 0, 0, 0);
        add_row(0, 0, REQ_SEARCH, KMAX, PMAX, LMAX, 1, STAT_MISSING, 0, 0, 0);
        add_row(0, 0, REQ_INSERT, KMAX, PMAX, LMAX, 0, 0, 0, 0, 0);
        add_row(0, 0, REQ_MODIFY, KMAX, 31'h2AAA_AAAA, LBL_B, 0, 0, 0, 0, 0);
        add_row(0, 0, REQ_CLEAR, KMAX, PMAX, LMAX, 1, STAT_OK, 0, 0, 0);
        add_row(0, 0, REQ_SEARCH, 0, 0, 0, 1, STAT_MISSING, 0, 0, 0);
        // zero size acts as one slot
        add_row(1, 0, REQ_INSERT, 123, 5, LBL_A, 1, STAT_OK, 0, 0, 0);
        add_row(0, 0, REQ_INSERT, 5, 6, LBL_B, 1, STAT_FULL, 0, 0, 0);
        add_row(0, 0, REQ_SEARCH, 123, 0, 0, 0, 0, 0, 0, 0);
        // oversize acts as full table
        add_row(1, 31, REQ_INSERT, 15, 1, LBL_A, 1, STAT_OK, 15, 0, 0);
        add_row(0, 0, REQ_INSERT, 31, 2, LBL_B, 1, STAT_FULL, 0, 0, 0);
        add_row(0, 0, REQ_INSERT, 3, 3, LBL_A, 0, 0, 0, 0, 0);
        add_row(0, 0, REQ_INSERT, 19, 4, LBL_B, 0, 0, 0, 0, 0);
        // shrink: link to slot 4 is stale
        add_row(1, 4, REQ_SEARCH, 19, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, REQ_INSERT, 7, 7, LBL_A, 0, 0, 0, 0, 0);
        add_row(1, 16, REQ_SEARCH, 19, 0, 0, 0, 0, 0, 0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].set_size)
            begin
                write_size(plan[i].size_val);
            end
            send_item(plan[i].item, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: sz = 5'd16;
                1: sz = 5'd1;
                2: sz = 5'd7;
                3: sz = 5'd31;
                4: sz = 5'd0;
                5: sz = CFG_W'($urandom_range(2, 15));
                6: sz = SIZE_RESET;
                7: sz = 5'd16;
                default: sz = CFG_W'($urandom_range(0, 31));
            endcase
            write_size(sz);
            steady = (p == 2);
            eff = (sz == 0) ? 1 : (sz > NSLOT) ? NSLOT : int'(sz);
            foreach (key_pool[k])
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    key_pool[k] = KEY_W'($urandom_range(0, 3) * eff + $urandom_range(0, 15));
                end
                else
                begin
                    key_pool[k] = KEY_W'($urandom);
                end
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 4 && n == PHASE_ITEMS / 2)
                begin
                    drain();
                end
                roll = $urandom_range(0, 99);
                if (roll < 40)
                begin
                    it.req_type = REQ_INSERT;
                end
                else if (roll < 70)
                begin
                    it.req_type = REQ_SEARCH;
                end
                else if (roll < 94)
                begin
                    it.req_type = REQ_MODIFY;
                end
                else
                begin
                    it.req_type = REQ_CLEAR;
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    it.record_key = key_pool[$urandom_range(0, POOL_N - 1)];
                end
                else
                begin
                    it.record_key = KEY_W'($urandom);
                end
                it.record_pay   = PAY_W'($urandom);
                it.record_label = {$urandom, $urandom};
                send_item(it, 1'b0, '0);
            end
        end
        steady = 1'b0;

        req_valid <= 1'b0;
        while (replies_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
